@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define WSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define WSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/wsh_pkg.sv @@
`timescale 1ns / 1ps

package wsh_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
  localparam int unsigned HALF_W     = WORD_W / 2;

  localparam logic [WORD_W-1:0] MIX_MUL  = 64'hd6e8_feb8_6659_fd93;
  localparam logic [WORD_W-1:0] SEED_KEY = 64'ha076_1d64_78bd_642f;
  localparam logic [WORD_W-1:0] WORD_KEY = 64'he703_7ed1_a0b4_28db;
  localparam logic [WORD_W-1:0] TAIL_KEY = 64'h8ebc_6af0_9c88_c6e3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] product;
  } mul_rsp_t;

  function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
    xor_shift = v ^ (v >> HALF_W);
  endfunction

  // keep only the low (len mod 8) bytes
  function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] nbytes);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      if (i < int'(nbytes)) m[i*8 +: 8] = 8'hff;
    end
    tail_mask = m;
  endfunction

endpackage

@@ hw/rtl/word_stream_hash64_unit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   | dir | tdata                              | tuser | tlast
// s_axis    | in  | total_length[63:0], data_word[127:64] | first | last
// m_axis    | out | hash_value[63:0]                   | -     | -
//
// an item is accepted, then takes two passes of the shared digit-serial
// multiplier (4-bit digits, each pass ending with done); a last item also
// loads the output register.
// reset clears the running hash and the stored length low bits to zero.
// the output register holds a finished hash until m_axis takes it, while
// the next item can already be accepted and worked on.
module word_stream_hash64_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,   // total_length[63:0], data_word[127:64]
  input  logic          s_axis_tuser_i,   // first
  input  logic          s_axis_tlast_i,   // last
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [63:0]   m_axis_tdata_o    // hash_value[63:0]
);

  wsh_pkg::state_e             state_q, state_d;
  logic [wsh_pkg::WORD_W-1:0]  hash_q, hash_d;
  logic [2:0]                  len_q, len_d;
  logic                        last_q, last_d;
  logic [wsh_pkg::WORD_W-1:0]  res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic [wsh_pkg::WORD_W-1:0]  out_data_q, out_data_d;

  wsh_pkg::mul_req_t           mul_req;
  wsh_pkg::mul_rsp_t           mul_rsp;

  logic                        accept;
  logic                        out_free;
  logic [wsh_pkg::WORD_W-1:0]  in_len, in_word;
  logic [wsh_pkg::WORD_W-1:0]  seed_hash;
  logic [2:0]                  seed_len;
  logic [wsh_pkg::WORD_W-1:0]  mix_in;
  logic                        in_mix_step;
  logic                        out_load;

  assign in_len   = s_axis_tdata_i[63:0];
  assign in_word  = s_axis_tdata_i[127:64];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign seed_hash = s_axis_tuser_i ? (wsh_pkg::SEED_KEY ^ in_len) : hash_q;
  assign seed_len  = s_axis_tuser_i ? in_len[2:0] : len_q;
  assign mix_in    = s_axis_tlast_i
                   ? (seed_hash ^ (in_word & wsh_pkg::tail_mask(seed_len)) ^ wsh_pkg::TAIL_KEY)
                   : (seed_hash ^ in_word ^ wsh_pkg::WORD_KEY);

  assign in_mix_step = (state_q == wsh_pkg::ST_MIX1) || (state_q == wsh_pkg::ST_MIX2);
  assign out_load    = (state_q == wsh_pkg::ST_OUT) && out_free;

  wsh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsh_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = wsh_pkg::ST_MIX1;
      wsh_pkg::ST_MIX1: if (mul_rsp.done) state_d = wsh_pkg::ST_MIX2;
      wsh_pkg::ST_MIX2: begin
        if (mul_rsp.done) state_d = last_q ? wsh_pkg::ST_OUT : wsh_pkg::ST_IDLE;
      end
      wsh_pkg::ST_OUT:  if (out_free) state_d = wsh_pkg::ST_IDLE;
      default:          state_d = wsh_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_req.start   = 1'b0;
    mul_req.operand = wsh_pkg::xor_shift(mul_rsp.product);
    hash_d          = hash_q;
    len_d           = len_q;
    last_d          = last_q;
    res_d           = res_q;
    out_valid_d     = out_valid_q && !m_axis_tready_i;
    out_data_d      = out_data_q;
    unique case (state_q)
      wsh_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mul_req.operand = wsh_pkg::xor_shift(mix_in);
        if (accept) begin
          mul_req.start = 1'b1;
          hash_d        = seed_hash;
          len_d         = seed_len;
          last_d        = s_axis_tlast_i;
        end
      end
      wsh_pkg::ST_MIX1: begin
        mul_req.start = mul_rsp.done;
      end
      wsh_pkg::ST_MIX2: begin
        if (mul_rsp.done) begin
          // a tail step leaves the running hash untouched
          if (last_q) res_d = wsh_pkg::xor_shift(mul_rsp.product);
          else        hash_d = wsh_pkg::xor_shift(mul_rsp.product);
        end
      end
      wsh_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsh_pkg::ST_IDLE;
      hash_q      <= '0;
      len_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      len_q       <= len_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `WSH_ASSERT(a_accept_starts, accept |=> state_q == wsh_pkg::ST_MIX1, "no mix step after accept")
  `WSH_ASSERT(a_done_in_mix, mul_rsp.done |-> in_mix_step, "multiplier done outside a mix step")
  `WSH_ASSERT(a_out_from_tail, $rose(out_valid_q) |-> $past(out_load), "hash shown without tail")

endmodule

@@ hw/rtl/wsh_mul.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// multiply by MIX_MUL mod 2^64, one 4-bit digit of the operand per cycle
module wsh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsh_pkg::mul_req_t req_i,
  output wsh_pkg::mul_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [wsh_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [wsh_pkg::WORD_W-1:0]     opnd_q, opnd_d;
  logic [wsh_pkg::WORD_W-1:0]     mcand_q, mcand_d;
  logic [wsh_pkg::WORD_W-1:0]     acc_q, acc_d;
  logic [wsh_pkg::WORD_W-1:0]     pp;

  // partial product of one digit against the shifted constant
  always_comb begin
    pp = '0;
    for (int i = 0; i < wsh_pkg::DIGIT_W; i++) begin
      if (opnd_q[i]) pp = pp + (mcand_q << i);
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    opnd_d  = opnd_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      opnd_d  = req_i.operand;
      mcand_d = wsh_pkg::MIX_MUL;
      acc_d   = '0;
    end else if (busy_q) begin
      acc_d   = acc_q + pp;
      opnd_d  = opnd_q >> wsh_pkg::DIGIT_W;
      mcand_d = mcand_q << wsh_pkg::DIGIT_W;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == wsh_pkg::CNT_W'(wsh_pkg::NUM_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q  <= opnd_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

  `WSH_ASSERT(a_no_start_busy, busy_q |-> !req_i.start, "multiplier restarted while busy")
  `WSH_ASSERT(a_done_idle, done_q |-> !busy_q && $past(busy_q), "done without a finished pass")
  `WSH_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !busy_q && !done_q, "multiplier active in reset")

endmodule
